[rtl/core/i2c_eeprom_transfer_sequencer_macros.svh]
// Assertion macros shared by the EEPROM transfer sequencer RTL.
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define I2CETS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define I2CETS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/i2cets_pkg.sv]
// Types and constants of the EEPROM transfer sequencer.
package i2cets_pkg;

    // event codes on the input channel
    localparam logic [1:0] ACT_REQ  = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_DONE = 2'd2;

    // request kinds
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_ERASE = 2'd3;

    // bus command kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    // completion status
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;
    localparam logic [1:0] ST_BADARG = 2'd3;

    // sequencer phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_WP_WAIT = 3'd1;
    localparam logic [2:0] PH_ISSUE   = 3'd2;
    localparam logic [2:0] PH_BUS     = 3'd3;
    localparam logic [2:0] PH_BURN    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_CHIP_BASE   = 2'd0;
    localparam logic [1:0] CFG_PAGE_BYTES  = 2'd1;
    localparam logic [1:0] CFG_WRITE_TICKS = 2'd2;
    localparam logic [1:0] CFG_WP_FITTED   = 2'd3;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [6:0]  chip_base;
        logic [8:0]  page_eff;     // page size, zero taken as one
        logic [15:0] write_ticks;
        logic        wp_fitted;
    } cfg_t;

    typedef struct packed {
        logic        accepted;
        logic        cmd_valid;
        logic [1:0]  cmd_kind;
        logic [6:0]  cmd_chip;
        logic [15:0] cmd_addr;
        logic [15:0] cmd_offset;
        logic [15:0] cmd_len;
        logic        wp_release;
        logic        done_res;
        logic [1:0]  status;
    } res_t;

endpackage

[rtl/core/i2cets_cfg.sv]
// Configuration register bank of the EEPROM transfer sequencer.
module i2cets_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [i2cets_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output i2cets_pkg::cfg_t                  cfg
);

    logic [6:0]  chip_base_reg;
    logic [8:0]  page_bytes_reg;
    logic [15:0] write_ticks_reg;
    logic        wp_fitted_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_base_reg   <= 7'd80;
            page_bytes_reg  <= 9'd32;
            write_ticks_reg <= 16'd5;
            wp_fitted_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                i2cets_pkg::CFG_CHIP_BASE:   chip_base_reg   <= cfg_wdata[6:0];
                i2cets_pkg::CFG_PAGE_BYTES:  page_bytes_reg  <= cfg_wdata[8:0];
                i2cets_pkg::CFG_WRITE_TICKS: write_ticks_reg <= cfg_wdata[15:0];
                i2cets_pkg::CFG_WP_FITTED:   wp_fitted_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.chip_base   = chip_base_reg;
        cfg.page_eff    = (page_bytes_reg == 9'd0) ? 9'd1 : page_bytes_reg;
        cfg.write_ticks = write_ticks_reg;
        cfg.wp_fitted   = wp_fitted_reg;
    end

endmodule

[rtl/core/i2c_eeprom_transfer_sequencer.sv]
// Top level of the EEPROM transfer sequencer: event decode, state and result register.
//
// Usage notes
// - s_ channel carries events: a new request, a time tick or a bus transfer
//   finished. Every accepted transfer yields exactly one result on m_.
// - A request starts a read (one bus command), a write (page-sized commands)
//   or an erase (16-byte fill commands). Requests while busy come back with
//   accepted low. Zero size, no mode or no data for a read/write ends with status 3.
// - Commands are handed out on ticks with bus_free set; the requester runs
//   the bus and reports back with a bus-done event.
// - The result for an event is registered, on m_ in the cycle after its transfer.
// - Throughput: one event per cycle while s_ready is high; the step is one pass
//   of compare/subtract logic between the input handshake and the result register.
// - s_ready stays high while the result register is empty or being drained,
//   so a stalled receiver holds one result and then back-pressures s_.
// - Reset (aresetn low, synchronous) empties the result register, returns the
//   sequencer to idle with write protect driven on, and loads the register
//   defaults: chip base 80, page 32 bytes, 5 write ticks, WP pin fitted.
// - Configuration writes via cfg_we/cfg_index/cfg_wdata take effect at once;
//   only write them while no request is in flight.
module i2c_eeprom_transfer_sequencer #(
    parameter int ADDR_BITS   = 17,
    parameter int SIZE_BITS   = 16,
    parameter int ERASE_CHUNK = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [i2cets_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_action,
    input  logic [1:0]                        s_req_mode,
    input  logic [ADDR_BITS-1:0]              s_req_address,
    input  logic [SIZE_BITS-1:0]              s_req_size,
    input  logic                              s_data_present,
    input  logic                              s_bus_free,
    input  logic                              s_wp_sensed,
    input  logic                              s_bus_ok,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic                              m_cmd_valid,
    output logic [1:0]                        m_cmd_kind,
    output logic [6:0]                        m_cmd_chip,
    output logic [15:0]                       m_cmd_addr,
    output logic [15:0]                       m_cmd_offset,
    output logic [15:0]                       m_cmd_len,
    output logic                              m_wp_release,
    output logic                              m_done_res,
    output logic [1:0]                        m_status
);

`include "i2c_eeprom_transfer_sequencer_macros.svh"

    // width for the chunk compare: wide enough for page size and byte count
    localparam int CW = (SIZE_BITS > 9) ? SIZE_BITS : 9;

    i2cets_pkg::cfg_t cfg;

    i2cets_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer state
    logic [2:0]           phase_reg,       phase_next;
    logic [1:0]           op_mode_reg,     op_mode_next;
    logic [ADDR_BITS-1:0] base_addr_reg,   base_addr_next;
    logic [SIZE_BITS-1:0] total_reg,       total_next;
    logic [SIZE_BITS-1:0] done_reg,        done_next;
    logic [SIZE_BITS-1:0] last_chunk_reg,  last_chunk_next;
    logic [15:0]          wait_reg,        wait_next;
    logic                 wp_rel_reg,      wp_rel_next;

    // result register
    logic                 m_valid_reg,     m_valid_next;
    i2cets_pkg::res_t     res_reg,         res_next;

    logic                 s_fire;

    // command built from current state
    logic [ADDR_BITS-1:0] cur_addr;
    logic [SIZE_BITS-1:0] remaining;
    logic [CW-1:0]        chunk_lim;
    logic [CW-1:0]        chunk;
    logic [SIZE_BITS-1:0] cmd_len;
    logic [1:0]           cmd_kind;
    logic [SIZE_BITS-1:0] done_sum;
    logic                 is_read;
    logic                 is_erase;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        is_read   = (op_mode_reg == i2cets_pkg::MODE_READ);
        is_erase  = (op_mode_reg == i2cets_pkg::MODE_ERASE);
        cur_addr  = is_read ? base_addr_reg
                            : ADDR_BITS'(base_addr_reg + ADDR_BITS'(done_reg));
        remaining = total_reg - done_reg;
        chunk_lim = is_erase ? CW'(ERASE_CHUNK) : CW'(cfg.page_eff);
        chunk     = (CW'(remaining) > chunk_lim) ? chunk_lim : CW'(remaining);
        cmd_len   = is_read ? total_reg : SIZE_BITS'(chunk);
        cmd_kind  = is_read ? i2cets_pkg::KIND_READ
                  : (is_erase ? i2cets_pkg::KIND_FILL : i2cets_pkg::KIND_WRITE);
        done_sum  = SIZE_BITS'(done_reg + last_chunk_reg);
    end

    // one event step
    always_comb begin
        phase_next      = phase_reg;
        op_mode_next    = op_mode_reg;
        base_addr_next  = base_addr_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        last_chunk_next = last_chunk_reg;
        wait_next       = wait_reg;
        wp_rel_next     = wp_rel_reg;
        res_next        = '0;

        unique case (s_action)
            i2cets_pkg::ACT_REQ: begin
                if (phase_reg == i2cets_pkg::PH_IDLE) begin
                    res_next.accepted = 1'b1;
                    op_mode_next      = s_req_mode;
                    base_addr_next    = s_req_address;
                    total_next        = s_req_size;
                    done_next         = '0;
                    last_chunk_next   = '0;
                    wait_next         = '0;
                    if (s_req_size == '0 || s_req_mode == i2cets_pkg::MODE_NONE ||
                        (!s_data_present && s_req_mode != i2cets_pkg::MODE_ERASE)) begin
                        phase_next        = i2cets_pkg::PH_IDLE;
                        wp_rel_next       = 1'b0;
                        res_next.done_res = 1'b1;
                        res_next.status   = i2cets_pkg::ST_BADARG;
                    end else if (s_req_mode == i2cets_pkg::MODE_READ) begin
                        phase_next = i2cets_pkg::PH_ISSUE;
                    end else begin
                        wp_rel_next = 1'b1;
                        phase_next  = i2cets_pkg::PH_WP_WAIT;
                    end
                end
            end
            i2cets_pkg::ACT_TICK: begin
                if (phase_reg == i2cets_pkg::PH_WP_WAIT) begin
                    if (!(cfg.wp_fitted && s_wp_sensed)) begin
                        phase_next = i2cets_pkg::PH_ISSUE;
                    end
                end else if (phase_reg == i2cets_pkg::PH_ISSUE) begin
                    if (s_bus_free) begin
                        last_chunk_next     = cmd_len;
                        res_next.cmd_valid  = 1'b1;
                        res_next.cmd_kind   = cmd_kind;
                        res_next.cmd_chip   = 7'(cfg.chip_base + 7'(cur_addr >> 16));
                        res_next.cmd_addr   = 16'(cur_addr);
                        res_next.cmd_offset = is_read ? 16'd0 : 16'(done_reg);
                        res_next.cmd_len    = 16'(cmd_len);
                        phase_next          = i2cets_pkg::PH_BUS;
                    end
                end else if (phase_reg == i2cets_pkg::PH_BURN) begin
                    if (wait_reg > 16'd1) begin
                        wait_next = wait_reg - 16'd1;
                    end else begin
                        done_next = done_sum;
                        if (done_sum >= total_reg) begin
                            phase_next        = i2cets_pkg::PH_IDLE;
                            wp_rel_next       = 1'b0;
                            res_next.done_res = 1'b1;
                            res_next.status   = i2cets_pkg::ST_OK;
                        end else begin
                            phase_next = i2cets_pkg::PH_ISSUE;
                        end
                    end
                end
            end
            i2cets_pkg::ACT_DONE: begin
                if (phase_reg == i2cets_pkg::PH_BUS) begin
                    if (!s_bus_ok) begin
                        phase_next        = i2cets_pkg::PH_IDLE;
                        wp_rel_next       = 1'b0;
                        res_next.done_res = 1'b1;
                        res_next.status   = i2cets_pkg::ST_FAULT;
                    end else if (is_read) begin
                        done_next         = total_reg;
                        phase_next        = i2cets_pkg::PH_IDLE;
                        wp_rel_next       = 1'b0;
                        res_next.done_res = 1'b1;
                        res_next.status   = i2cets_pkg::ST_OK;
                    end else begin
                        wait_next  = cfg.write_ticks;
                        phase_next = i2cets_pkg::PH_BURN;
                    end
                end
            end
            default: ;  // unused event code: no change
        endcase

        res_next.wp_release = wp_rel_next;

        m_valid_next = s_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= i2cets_pkg::PH_IDLE;
            op_mode_reg    <= i2cets_pkg::MODE_NONE;
            base_addr_reg  <= '0;
            total_reg      <= '0;
            done_reg       <= '0;
            last_chunk_reg <= '0;
            wait_reg       <= '0;
            wp_rel_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                phase_reg      <= phase_next;
                op_mode_reg    <= op_mode_next;
                base_addr_reg  <= base_addr_next;
                total_reg      <= total_next;
                done_reg       <= done_next;
                last_chunk_reg <= last_chunk_next;
                wait_reg       <= wait_next;
                wp_rel_reg     <= wp_rel_next;
            end
        end
    end

    // result payload: no reset needed, qualified by m_valid
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_accepted   = res_reg.accepted;
    assign m_cmd_valid  = res_reg.cmd_valid;
    assign m_cmd_kind   = res_reg.cmd_kind;
    assign m_cmd_chip   = res_reg.cmd_chip;
    assign m_cmd_addr   = res_reg.cmd_addr;
    assign m_cmd_offset = res_reg.cmd_offset;
    assign m_cmd_len    = res_reg.cmd_len;
    assign m_wp_release = res_reg.wp_release;
    assign m_done_res   = res_reg.done_res;
    assign m_status     = res_reg.status;

    // issuing a command always leaves the sequencer waiting on the bus
    `I2CETS_ASSERT_NEXT(a_issue_to_bus, s_fire && res_next.cmd_valid, phase_reg == i2cets_pkg::PH_BUS, "command issued but not waiting for bus")
    // completion returns to idle with write protect back on
    `I2CETS_ASSERT_NEXT(a_done_idle, s_fire && res_next.done_res, phase_reg == i2cets_pkg::PH_IDLE && !wp_rel_reg, "completion did not restore idle and protection")
    // protection is only lifted while a write or erase is in flight
    `I2CETS_ASSERT_NOW(a_wp_busy, wp_rel_reg, phase_reg != i2cets_pkg::PH_IDLE && op_mode_reg != i2cets_pkg::MODE_READ, "write protect lifted outside a write or erase")
    // a non-zero status only comes with a completion
    `I2CETS_ASSERT_NOW(a_status_done, m_valid && m_status != i2cets_pkg::ST_NONE, m_done_res, "status without completion")

endmodule

[test/testbench.sv]
// Self-checking testbench for the I2C EEPROM transfer sequencer.
module testbench;
    import i2cets_pkg::*;

    localparam int ADDR_W     = 17;
    localparam int SIZE_W     = 16;
    localparam int FILL_CHUNK = 16;
    localparam int unsigned ADDR_MASK = (1 << ADDR_W) - 1;
    localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

    // action code the block must treat as a no-op
    localparam logic [1:0] ACT_STRAY = 2'd3;

    localparam int RANDOM_ITEMS = 1600;
    localparam int RANDOM_SETS  = 5;

    // one event on the s_ channel
    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        req_mode;
        logic [ADDR_W-1:0] req_address;
        logic [SIZE_W-1:0] req_size;
        logic              data_present;
        logic              bus_free;
        logic              wp_sensed;
        logic              bus_ok;
    } seq_event_t;

    // directed row: the event, plus a hand-written result where one is given
    typedef struct packed {
        seq_event_t ev;
        logic       typed;
        res_t       want;
    } dir_row_t;

    localparam res_t RES_QUIET  = '0;
    localparam res_t RES_BADARG =
        '{1'b1, 1'b0, KIND_READ, 7'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, ST_BADARG};

    logic                aclk;
    logic                aresetn = 1'b0;

    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = CFG_CHIP_BASE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_action = ACT_TICK;
    logic [1:0]          s_req_mode = MODE_NONE;
    logic [ADDR_W-1:0]   s_req_address = '0;
    logic [SIZE_W-1:0]   s_req_size = '0;
    logic                s_data_present = 1'b0;
    logic                s_bus_free = 1'b0;
    logic                s_wp_sensed = 1'b0;
    logic                s_bus_ok = 1'b0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_accepted;
    logic                m_cmd_valid;
    logic [1:0]          m_cmd_kind;
    logic [6:0]          m_cmd_chip;
    logic [15:0]         m_cmd_addr;
    logic [15:0]         m_cmd_offset;
    logic [15:0]         m_cmd_len;
    logic                m_wp_release;
    logic                m_done_res;
    logic [1:0]          m_status;

    i2c_eeprom_transfer_sequencer #(
        .ADDR_BITS  (ADDR_W),
        .SIZE_BITS  (SIZE_W),
        .ERASE_CHUNK(FILL_CHUNK)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_req_mode    (s_req_mode),
        .s_req_address (s_req_address),
        .s_req_size    (s_req_size),
        .s_data_present(s_data_present),
        .s_bus_free    (s_bus_free),
        .s_wp_sensed   (s_wp_sensed),
        .s_bus_ok      (s_bus_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_cmd_valid   (m_cmd_valid),
        .m_cmd_kind    (m_cmd_kind),
        .m_cmd_chip    (m_cmd_chip),
        .m_cmd_addr    (m_cmd_addr),
        .m_cmd_offset  (m_cmd_offset),
        .m_cmd_len     (m_cmd_len),
        .m_wp_release  (m_wp_release),
        .m_done_res    (m_done_res),
        .m_status      (m_status)
    );

    // ------------------------------------------------------------------
    // Sequencer shadow: register copy and request state, reset values
    // ------------------------------------------------------------------
    logic [6:0]        cfg_chip_base   = 7'd80;
    logic [8:0]        cfg_page_bytes  = 9'd32;
    logic [15:0]       cfg_write_ticks = 16'd5;
    logic              cfg_wp_fitted   = 1'b1;

    logic [2:0]        seq_phase = PH_IDLE;
    logic [1:0]        seq_mode  = MODE_NONE;
    logic [ADDR_W-1:0] seq_base  = '0;
    logic [SIZE_W-1:0] seq_total = '0;
    logic [SIZE_W-1:0] seq_done  = '0;
    logic [SIZE_W-1:0] seq_chunk = '0;
    logic [15:0]       seq_wait  = '0;
    logic              wp_lifted = 1'b0;

    res_t              pending_results [$];
    res_t              expected_now;
    int                mismatch_count = 0;
    int                result_index   = 0;
    int                burst_left     = 0;
    int                ready_run      = 0;
    int                random_items   = 0;

    // every completion re-protects the part and reports its status
    function automatic void close_request(inout res_t r, input logic [1:0] st);
        seq_phase  = PH_IDLE;
        wp_lifted  = 1'b0;
        r.done_res = 1'b1;
        r.status   = st;
    endfunction

    // one event in, one result out; updates the shadow state
    function automatic res_t advance_sequencer(input seq_event_t ev);
        res_t        r;
        int unsigned cur;
        int unsigned left;
        int unsigned span;
        int unsigned len;
        r = '0;
        case (ev.action)
            ACT_REQ: begin
                if (seq_phase == PH_IDLE) begin
                    r.accepted = 1'b1;
                    seq_mode   = ev.req_mode;
                    seq_base   = ev.req_address;
                    seq_total  = ev.req_size;
                    seq_done   = '0;
                    seq_chunk  = '0;
                    seq_wait   = '0;
                    if (ev.req_size == 0 || ev.req_mode == MODE_NONE ||
                        (!ev.data_present && ev.req_mode != MODE_ERASE)) begin
                        close_request(r, ST_BADARG);
                    end else if (ev.req_mode == MODE_READ) begin
                        seq_phase = PH_ISSUE;
                    end else begin
                        wp_lifted = 1'b1;
                        seq_phase = PH_WP_WAIT;
                    end
                end
            end
            ACT_TICK: begin
                case (seq_phase)
                    PH_WP_WAIT: begin
                        if (!(cfg_wp_fitted && ev.wp_sensed)) seq_phase = PH_ISSUE;
                    end
                    PH_ISSUE: begin
                        if (ev.bus_free) begin
                            if (seq_mode == MODE_READ) begin
                                cur        = 32'(seq_base);
                                len        = 32'(seq_total);
                                r.cmd_kind = KIND_READ;
                            end else begin
                                cur  = (32'(seq_base) + 32'(seq_done)) & ADDR_MASK;
                                left = 32'(seq_total) - 32'(seq_done);
                                if (seq_mode == MODE_ERASE) span = FILL_CHUNK;
                                else span = (cfg_page_bytes == 0) ? 1 : 32'(cfg_page_bytes);
                                len        = (left > span) ? span : left;
                                r.cmd_kind = (seq_mode == MODE_ERASE) ? KIND_FILL : KIND_WRITE;
                                r.cmd_offset = seq_done;
                            end
                            seq_chunk   = len[15:0];
                            r.cmd_valid = 1'b1;
                            // bank bits above bit 15 add onto the device address
                            r.cmd_chip  = cfg_chip_base + 7'(cur >> 16);
                            r.cmd_addr  = cur[15:0];
                            r.cmd_len   = len[15:0];
                            seq_phase   = PH_BUS;
                        end
                    end
                    PH_BURN: begin
                        if (seq_wait > 1) begin
                            seq_wait = seq_wait - 1'b1;
                        end else begin
                            seq_done = seq_done + seq_chunk;
                            if (seq_done >= seq_total) close_request(r, ST_OK);
                            else seq_phase = PH_ISSUE;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_DONE: begin
                if (seq_phase == PH_BUS) begin
                    if (!ev.bus_ok) begin
                        close_request(r, ST_FAULT);
                    end else if (seq_mode == MODE_READ) begin
                        seq_done = seq_total;
                        close_request(r, ST_OK);
                    end else begin
                        seq_wait  = cfg_write_ticks;
                        seq_phase = PH_BURN;
                    end
                end
            end
            default: ;
        endcase
        r.wp_release = wp_lifted;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic seq_event_t any_event();
        seq_event_t ev;
        ev.action       = 2'($urandom_range(0, 3));
        ev.req_mode     = 2'($urandom_range(0, 3));
        ev.req_address  = ADDR_W'($urandom);
        ev.req_size     = SIZE_W'($urandom);
        ev.data_present = 1'($urandom);
        ev.bus_free     = 1'($urandom);
        ev.wp_sensed    = 1'($urandom);
        ev.bus_ok       = 1'($urandom);
        return ev;
    endfunction

    // request with random content, now and then malformed; writes and erases kept to
    // at most ten chunks so the run stays short
    function automatic seq_event_t make_request();
        seq_event_t  ev;
        int unsigned span;
        ev = any_event();
        ev.action       = ACT_REQ;
        ev.req_mode     = ($urandom_range(0, 32) == 0) ? MODE_NONE : 2'($urandom_range(1, 3));
        ev.data_present = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 4) == 0)
            ev.req_address = ADDR_TOP - ADDR_W'($urandom_range(0, 300));
        if (ev.req_mode == MODE_ERASE) span = FILL_CHUNK * 10;
        else span = ((cfg_page_bytes == 0) ? 1 : 32'(cfg_page_bytes)) * 10;
        if (ev.req_mode == MODE_WRITE || ev.req_mode == MODE_ERASE)
            ev.req_size = SIZE_W'($urandom_range(1, span));
        else if ($urandom_range(0, 1) == 0)
            ev.req_size = SIZE_W'($urandom_range(1, 64));
        if ($urandom_range(0, 24) == 0) ev.req_size = '0;
        return ev;
    endfunction

    // Push one event through s_. The sender runs in bursts; at a burst end it
    // drops valid, and now and then it holds off until every
    // outstanding result has come back.
    task automatic send_event(input seq_event_t ev, input logic typed, input res_t want);
        res_t got;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end else if ($urandom_range(0, 199) == 0) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (pending_results.size() != 0);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_action       <= ev.action;
        s_req_mode     <= ev.req_mode;
        s_req_address  <= ev.req_address;
        s_req_size     <= ev.req_size;
        s_data_present <= ev.data_present;
        s_bus_free     <= ev.bus_free;
        s_wp_sensed    <= ev.wp_sensed;
        s_bus_ok       <= ev.bus_ok;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // transfer taken at this edge
        got = advance_sequencer(ev);
        pending_results.push_back(typed ? want : got);
    endtask

    // one request, then events that move it on (with some noise) until idle
    task automatic run_transaction(input seq_event_t req);
        seq_event_t ev;
        send_event(req, 1'b0, RES_QUIET);
        random_items++;
        while (seq_phase != PH_IDLE) begin
            ev = any_event();
            if ($urandom_range(0, 9) != 0) begin
                case (seq_phase)
                    PH_WP_WAIT: begin
                        ev.action    = ACT_TICK;
                        ev.wp_sensed = ($urandom_range(0, 2) == 0);
                    end
                    PH_ISSUE: begin
                        ev.action   = ACT_TICK;
                        ev.bus_free = ($urandom_range(0, 3) != 0);
                    end
                    PH_BUS: begin
                        ev.action = ACT_DONE;
                        ev.bus_ok = ($urandom_range(0, 24) != 0);
                    end
                    default: ev.action = ACT_TICK;
                endcase
            end
            send_event(ev, 1'b0, RES_QUIET);
            random_items++;
        end
    endtask

    // idle the sender until every result is back, then let the block settle
    task automatic await_results(input int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // all four registers, one per cycle; only called with the block idle
    task automatic load_settings(input logic [6:0] chip, input logic [8:0] page,
                                 input logic [15:0] ticks, input logic wp_pin);
        logic [1:0]            slot  [4];
        logic [CFG_DATA_W-1:0] value [4];
        slot  = '{CFG_CHIP_BASE, CFG_PAGE_BYTES, CFG_WRITE_TICKS, CFG_WP_FITTED};
        value = '{CFG_DATA_W'(chip), CFG_DATA_W'(page), ticks, CFG_DATA_W'(wp_pin)};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= slot[i];
            cfg_wdata <= value[i];
            @(posedge aclk);
        end
        cfg_we          <= 1'b0;
        cfg_chip_base   = chip;
        cfg_page_bytes  = page;
        cfg_write_ticks = ticks;
        cfg_wp_fitted   = wp_pin;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string what);
        $display("mismatch, result %0d: %s", result_index, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) log_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                log_mismatch("result with no transfer outstanding");
            end else begin
                expected_now = pending_results.pop_front();
                check_field("accepted",   16'(m_accepted),   16'(expected_now.accepted));
                check_field("cmd_valid",  16'(m_cmd_valid),  16'(expected_now.cmd_valid));
                check_field("cmd_kind",   16'(m_cmd_kind),   16'(expected_now.cmd_kind));
                check_field("cmd_chip",   16'(m_cmd_chip),   16'(expected_now.cmd_chip));
                check_field("cmd_addr",   m_cmd_addr,        expected_now.cmd_addr);
                check_field("cmd_offset", m_cmd_offset,      expected_now.cmd_offset);
                check_field("cmd_len",    m_cmd_len,         expected_now.cmd_len);
                check_field("wp_release", 16'(m_wp_release), 16'(expected_now.wp_release));
                check_field("done_res",   16'(m_done_res),   16'(expected_now.done_res));
                check_field("status",     16'(m_status),     16'(expected_now.status));
            end
            result_index++;
        end
    end

    // Receiver: short stalls between ready runs, now and then a long ready run
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            ready_run <= 0;
        end else if (ready_run == 0) begin
            if (m_ready) begin
                m_ready   <= 1'b0;
                ready_run <= $urandom_range(1, 5);
            end else begin
                m_ready   <= 1'b1;
                ready_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 12);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    // ------------------------------------------------------------------
    // Clock, run limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directed table, run at reset register values.
    // Walks the idle no-ops, every bad-argument path, a rejected request
    // while busy, a two-chunk erase whose second chunk wraps past the top
    // of the address space and ends in a bus fault, then a full-size read
    // from the very last byte.
    // ------------------------------------------------------------------
    dir_row_t directed_rows [26] = '{
        // idle: tick, bus-done and unused action change nothing
        '{'{ACT_TICK, MODE_READ, ADDR_TOP, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, RES_QUIET},
        '{'{ACT_DONE, MODE_ERASE, 17'h0, 16'h0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, RES_QUIET},
        '{'{ACT_STRAY, MODE_WRITE, 17'h15555, 16'hAAAA, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1, RES_QUIET},
        // bad arguments: zero size, no mode, no buffer for write and read
        '{'{ACT_REQ, MODE_WRITE, 17'h00100, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, RES_BADARG},
        '{'{ACT_REQ, MODE_NONE, 17'h00040, 16'd5, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, RES_BADARG},
        '{'{ACT_REQ, MODE_WRITE, 17'h00020, 16'd8, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b1, RES_BADARG},
        '{'{ACT_REQ, MODE_READ, 17'h10000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, RES_BADARG},
        // erase needs no buffer: taken, protection lifted
        '{'{ACT_REQ, MODE_ERASE, 17'h1FFF8, 16'd20, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{1'b1, 1'b0, KIND_READ, 7'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, ST_NONE}},
        // busy: turned away
        '{'{ACT_REQ, MODE_READ, 17'h0, 16'd1, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b1,
          '{1'b0, 1'b0, KIND_READ, 7'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, ST_NONE}},
        // pin still protected, stray bus-done, pin released
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, RES_QUIET},
        '{'{ACT_DONE, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        // bus not free, then first fill chunk, then a tick while on the bus
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        // bus done, then the five-tick write cycle
        '{'{ACT_DONE, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        // second chunk wraps round to the bottom of the space, then a bus fault
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        '{'{ACT_DONE, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        // largest read from the last byte: upper bank, full length
        '{'{ACT_REQ, MODE_READ, ADDR_TOP, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, RES_QUIET},
        '{'{ACT_TICK, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 1'b1, KIND_READ, 7'd81, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0, 1'b0, ST_NONE}},
        '{'{ACT_DONE, MODE_NONE, 17'h0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{1'b0, 1'b0, KIND_READ, 7'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, ST_OK}}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        seq_event_t ev;
        int         set_end;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        // long write cycle: one single-chunk write waits out 200 ticks
        await_results(4);
        load_settings(7'd80, 9'd32, 16'd200, 1'b1);
        ev = make_request();
        ev.req_mode     = MODE_WRITE;
        ev.data_present = 1'b1;
        ev.req_size     = SIZE_W'($urandom_range(1, 32));
        run_transaction(ev);

        // random requests under several register settings, extremes included
        for (int set = 0; set < RANDOM_SETS; set++) begin
            await_results(4);
            case (set)
                0: load_settings(7'd127, 9'd256, 16'd0, 1'b0);
                1: load_settings(7'd0, 9'd1, 16'd1, 1'b1);
                2: load_settings(7'($urandom), 9'd0, 16'd2, 1'b1);
                3: load_settings(7'($urandom), 9'($urandom_range(1, 256)),
                                 16'($urandom_range(3, 6)), 1'($urandom));
                default: load_settings(7'd80, 9'd32, 16'd5, 1'b1);
            endcase
            set_end = random_items + RANDOM_ITEMS / RANDOM_SETS;
            while (random_items < set_end) begin
                // occasional idle noise: ignored, so not counted
                if ($urandom_range(0, 9) == 0) begin
                    ev = any_event();
                    ev.action = 2'($urandom_range(1, 3));
                    send_event(ev, 1'b0, RES_QUIET);
                end
                run_transaction(make_request());
            end
        end

        await_results(8);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
